// ===== hdl/mdru_pkg.sv =====
// Shared types, register addresses and codes of the multiply/divide register unit.
`default_nettype none

package mdru_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [15:0] ADDR_MUL_A    = 16'h4202;
    localparam logic [15:0] ADDR_MUL_B    = 16'h4203;
    localparam logic [15:0] ADDR_DVD_LO   = 16'h4204;
    localparam logic [15:0] ADDR_DVD_HI   = 16'h4205;
    localparam logic [15:0] ADDR_DIVISOR  = 16'h4206;
    localparam logic [15:0] ADDR_QUOT_LO  = 16'h4214;
    localparam logic [15:0] ADDR_QUOT_HI  = 16'h4215;
    localparam logic [15:0] ADDR_REM_LO   = 16'h4216;
    localparam logic [15:0] ADDR_REM_HI   = 16'h4217;
    localparam logic [15:0] ADDR_MTX_A    = 16'h211B;
    localparam logic [15:0] ADDR_MTX_B    = 16'h211C;
    localparam logic [15:0] ADDR_MTX_L0   = 16'h211D;
    localparam logic [15:0] ADDR_MTX_L1   = 16'h211E;
    localparam logic [15:0] ADDR_MTX_L2   = 16'h211F;
    localparam logic [15:0] ADDR_MTX_L3   = 16'h2120;
    localparam logic [15:0] ADDR_SPROD_LO = 16'h2134;
    localparam logic [15:0] ADDR_SPROD_MD = 16'h2135;
    localparam logic [15:0] ADDR_SPROD_HI = 16'h2136;

    localparam logic [15:0] QUOT_DIV_ZERO = 16'hFFFF;

    localparam logic [3:0] LAST_MUL_STEP = 4'd7;
    localparam logic [3:0] LAST_DIV_STEP = 4'd15;

    typedef enum logic [1:0] {
        OP_MUL_U = 2'd0,
        OP_MUL_S = 2'd1,
        OP_DIV   = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       hit;
    } rsp_t;

    typedef struct packed {
        logic        start;
        arith_op_t   op;
        logic [15:0] a;
        logic [7:0]  b;
    } arith_ctl_t;

    typedef struct packed {
        logic        done;
        logic [23:0] prod;
        logic [15:0] quot;
        logic [7:0]  rem;
    } arith_res_t;

endpackage

`default_nettype wire

// ===== hdl/multiply_divide_register_unit.sv =====
// Multiply/divide register unit: bus access decode, result registers and response stage.
//
// Usage: one bus access per request transfer (cmd, addr, wdata); exactly one
// response transfer (rdata, hit) follows each request, in order.
// Reads and plain register writes answer in the cycle after the request transfer
// when the response register is free. Writes that start arithmetic run the
// shared bit-serial unit one bit per cycle: 8 steps for either multiply,
// 16 steps for the divide, then the done flag, the emit state and the response
// register follow. A divide by zero starts no arithmetic; it answers like a plain write.
// req_stall is high while an access is being worked on or its response waits
// for its slot; the unit takes one access at a time.
// A response held under rsp_stall stays unchanged; the next request is taken
// as soon as the unit is back in idle.
// Reset clears all result and operand registers to zero and empties the
// response register.
`default_nettype none

module multiply_divide_register_unit (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            req_valid,
    output logic           req_stall,
    input  mdru_pkg::req_t req,
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output mdru_pkg::rsp_t rsp
);
    import mdru_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;
    rsp_t        hold_reg, hold_next;
    arith_op_t   pend_op_reg, pend_op_next;

    logic [7:0]  mul_a_reg, mul_a_next;
    logic [7:0]  dvd_lo_reg, dvd_lo_next;
    logic [7:0]  dvd_hi_reg, dvd_hi_next;
    logic [15:0] quot_reg, quot_next;
    logic [15:0] rop_reg, rop_next;
    logic [15:0] mtx_a_reg, mtx_a_next;
    logic [7:0]  latch_reg, latch_next;
    logic [23:0] sprod_reg, sprod_next;

    arith_ctl_t  actl;
    arith_res_t  ares;

    logic        accept;
    logic        out_free;
    rsp_t        dec;
    logic        needs_arith;

    mdru_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (actl),
        .res   (ares)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // access decode, plain register updates and arithmetic result capture
    always_comb
    begin
        dec         = '0;
        needs_arith = 1'b0;
        actl        = '0;
        mul_a_next  = mul_a_reg;
        dvd_lo_next = dvd_lo_reg;
        dvd_hi_next = dvd_hi_reg;
        quot_next   = quot_reg;
        rop_next    = rop_reg;
        mtx_a_next  = mtx_a_reg;
        latch_next  = latch_reg;
        sprod_next  = sprod_reg;
        if (accept)
        begin
            if (req.cmd == CMD_WRITE)
            begin
                case (req.addr)
                    ADDR_MUL_A:
                    begin
                        dec.hit    = 1'b1;
                        mul_a_next = req.wdata;
                    end
                    ADDR_MUL_B:
                    begin
                        dec.hit     = 1'b1;
                        needs_arith = 1'b1;
                        actl.op     = OP_MUL_U;
                        actl.a      = {8'd0, mul_a_reg};
                        actl.b      = req.wdata;
                    end
                    ADDR_DVD_LO:
                    begin
                        dec.hit     = 1'b1;
                        dvd_lo_next = req.wdata;
                    end
                    ADDR_DVD_HI:
                    begin
                        dec.hit     = 1'b1;
                        dvd_hi_next = req.wdata;
                    end
                    ADDR_DIVISOR:
                    begin
                        dec.hit = 1'b1;
                        if (req.wdata == 8'd0)
                        begin
                            quot_next = QUOT_DIV_ZERO;
                            rop_next  = {dvd_hi_reg, dvd_lo_reg};
                        end
                        else
                        begin
                            needs_arith = 1'b1;
                            actl.op     = OP_DIV;
                            actl.a      = {dvd_hi_reg, dvd_lo_reg};
                            actl.b      = req.wdata;
                        end
                    end
                    ADDR_MTX_A:
                    begin
                        dec.hit    = 1'b1;
                        mtx_a_next = {req.wdata, latch_reg};
                        latch_next = req.wdata;
                    end
                    ADDR_MTX_B:
                    begin
                        dec.hit     = 1'b1;
                        latch_next  = req.wdata;
                        needs_arith = 1'b1;
                        actl.op     = OP_MUL_S;
                        actl.a      = mtx_a_reg;
                        actl.b      = req.wdata;
                    end
                    ADDR_MTX_L0, ADDR_MTX_L1, ADDR_MTX_L2, ADDR_MTX_L3:
                    begin
                        dec.hit    = 1'b1;
                        latch_next = req.wdata;
                    end
                    default:
                    begin
                        dec.hit = 1'b0;
                    end
                endcase
            end
            else
            begin
                dec.hit = 1'b1;
                case (req.addr)
                    ADDR_QUOT_LO:  dec.rdata = quot_reg[7:0];
                    ADDR_QUOT_HI:  dec.rdata = quot_reg[15:8];
                    ADDR_REM_LO:   dec.rdata = rop_reg[7:0];
                    ADDR_REM_HI:   dec.rdata = rop_reg[15:8];
                    ADDR_SPROD_LO: dec.rdata = sprod_reg[7:0];
                    ADDR_SPROD_MD: dec.rdata = sprod_reg[15:8];
                    ADDR_SPROD_HI: dec.rdata = sprod_reg[23:16];
                    default:       dec.hit   = 1'b0;
                endcase
            end
        end
        actl.start = needs_arith;

        if (ares.done)
        begin
            case (pend_op_reg)
                OP_MUL_U: rop_next   = ares.prod[15:0];
                OP_MUL_S: sprod_next = ares.prod;
                OP_DIV:
                begin
                    quot_next = ares.quot;
                    rop_next  = {8'd0, ares.rem};
                end
                default:  rop_next   = rop_reg;
            endcase
        end
    end

    // sequencing and response register
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        hold_next      = hold_reg;
        pend_op_next   = pend_op_reg;
        if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hold_next    = dec;
                    pend_op_next = actl.op;
                    if (needs_arith)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = dec;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RUN:
            begin
                if (ares.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = hold_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            pend_op_reg   <= OP_MUL_U;
            mul_a_reg     <= 8'd0;
            dvd_lo_reg    <= 8'd0;
            dvd_hi_reg    <= 8'd0;
            quot_reg      <= 16'd0;
            rop_reg       <= 16'd0;
            mtx_a_reg     <= 16'd0;
            latch_reg     <= 8'd0;
            sprod_reg     <= 24'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_op_reg   <= pend_op_next;
            mul_a_reg     <= mul_a_next;
            dvd_lo_reg    <= dvd_lo_next;
            dvd_hi_reg    <= dvd_hi_next;
            quot_reg      <= quot_next;
            rop_reg       <= rop_next;
            mtx_a_reg     <= mtx_a_next;
            latch_reg     <= latch_next;
            sprod_reg     <= sprod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ares.done |-> (state_reg == ST_RUN))
        else $error("arithmetic finished outside a run");

    a_run_is_hit_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (hold_reg.hit && (hold_reg.rdata == 8'd0)))
        else $error("arithmetic running for a non-write response");

    a_emit_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> (rsp_valid && (state_reg == ST_IDLE)))
        else $error("held response not issued");

endmodule

`default_nettype wire

// ===== hdl/mdru_arith.sv =====
// Bit-serial shift-add multiplier and restoring divider shared by all operations.
`default_nettype none

module mdru_arith (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mdru_pkg::arith_ctl_t ctl,
    output mdru_pkg::arith_res_t res
);
    import mdru_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  count_reg, count_next;
    arith_op_t   op_reg, op_next;
    logic [15:0] a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [17:0] hi_reg, hi_next;
    logic [15:0] lo_reg, lo_next;

    logic [17:0] aext;
    logic [17:0] addend;
    logic [17:0] msum;
    logic [8:0]  shifted;
    logic [9:0]  diff;
    logic        last;

    always_comb
    begin
        aext    = (op_reg == OP_MUL_S) ? {{2{a_reg[15]}}, a_reg} : {2'b00, a_reg};
        addend  = lo_reg[0] ? aext : 18'd0;
        // top multiplier bit carries negative weight for the signed form
        msum    = ((op_reg == OP_MUL_S) && (count_reg == LAST_MUL_STEP))
                  ? (hi_reg - addend) : (hi_reg + addend);
        shifted = {hi_reg[7:0], lo_reg[15]};
        diff    = {1'b0, shifted} - {2'b00, b_reg};
        last    = (op_reg == OP_DIV) ? (count_reg == LAST_DIV_STEP)
                                     : (count_reg == LAST_MUL_STEP);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            count_next = 4'd0;
            op_next    = ctl.op;
            a_next     = ctl.a;
            b_next     = ctl.b;
            hi_next    = 18'd0;
            lo_next    = (ctl.op == OP_DIV) ? ctl.a : {8'd0, ctl.b};
        end
        else if (busy_reg)
        begin
            count_next = count_reg + 4'd1;
            if (op_reg == OP_DIV)
            begin
                if (!diff[9])
                begin
                    hi_next = {9'd0, diff[8:0]};
                    lo_next = {lo_reg[14:0], 1'b1};
                end
                else
                begin
                    hi_next = {9'd0, shifted};
                    lo_next = {lo_reg[14:0], 1'b0};
                end
            end
            else
            begin
                hi_next = {msum[17], msum[17:1]};
                lo_next = {8'd0, msum[0], lo_reg[7:1]};
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 4'd0;
            op_reg    <= OP_MUL_U;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign res.done = done_reg;
    assign res.prod = {hi_reg[15:0], lo_reg[7:0]};
    assign res.quot = lo_reg;
    assign res.rem  = hi_reg[7:0];

endmodule

`default_nettype wire
